[rtl/hevc_dolby_vision_layer_splitter_macros.svh]
// assertion macros for the layer splitter rtl
// expects clk and rst_n in the scope of each use
`ifndef HEVC_DOLBY_VISION_LAYER_SPLITTER_MACROS_SVH
`define HEVC_DOLBY_VISION_LAYER_SPLITTER_MACROS_SVH

// consequent checked in the same cycle
`define HDVLS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define HDVLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hdvls_pkg.sv]
// shared types and constants of the layer splitter
// item structs, configuration struct, queued run format; no dependencies
package hdvls_pkg;

  localparam int CFG_ADDR_W  = 6;
  localparam int CFG_DATA_W  = 64;
  localparam int TYPE_W      = 6;
  localparam int MAX_RUN     = 6;
  localparam int RUN_CNT_W   = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] REG_BASE_ENABLE     = 3'd0;
  localparam logic [2:0] REG_ENH_ENABLE      = 3'd1;
  localparam logic [2:0] REG_WRAPPER_TYPE    = 3'd2;
  localparam logic [2:0] REG_RPU_TYPE        = 3'd3;
  localparam logic [2:0] REG_SHORT_CODE_MASK = 3'd4;
  localparam logic [2:0] REG_WARN_THRESHOLD  = 3'd5;

  localparam logic              RST_BASE_ENABLE     = 1'b1;
  localparam logic              RST_ENH_ENABLE      = 1'b1;
  localparam logic [TYPE_W-1:0] RST_WRAPPER_TYPE    = 6'd63;
  localparam logic [TYPE_W-1:0] RST_RPU_TYPE        = 6'd62;
  localparam logic [63:0]       RST_SHORT_CODE_MASK = 64'd0;
  localparam logic [TYPE_W-1:0] RST_WARN_THRESHOLD  = 6'd32;

  localparam logic [TYPE_W-1:0] RPU_COUNT_MAX = 6'd63;

  // element 3 goes out first
  localparam logic [3:0][7:0] SYNC_BYTES = {8'h00, 8'h00, 8'h00, 8'h01};

  typedef struct packed {
    logic [7:0] in_byte;
    logic       packet_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_layer;
    logic       unit_first;
    logic       run_last;
    logic       single_layer_warn;
  } out_item_t;

  typedef struct packed {
    logic              base_enable;
    logic              enh_enable;
    logic [TYPE_W-1:0] wrapper_type;
    logic [TYPE_W-1:0] rpu_type;
    logic [63:0]       short_code_mask;
    logic [TYPE_W-1:0] warn_threshold;
  } cfg_t;

  // all result bytes caused by one input item
  typedef struct packed {
    logic [RUN_CNT_W-1:0]      cnt;
    logic [MAX_RUN-1:0][7:0]   data;
    logic [MAX_RUN-1:0]        first;
    logic                      layer;
    logic                      warn;
  } run_t;

  typedef struct packed {
    logic valid;
    run_t run;
  } push_t;

endpackage

[rtl/hdvls_cfg.sv]
// configuration registers of the layer splitter behind an apb-style port
// depends on hdvls_pkg
module hdvls_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hdvls_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [hdvls_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [hdvls_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready,
  output hdvls_pkg::cfg_t                     cfg
);

  hdvls_pkg::cfg_t cfg_r, cfg_nxt;
  logic            wr_en;
  logic [2:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[5:3];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        hdvls_pkg::REG_BASE_ENABLE:     cfg_nxt.base_enable     = pwdata[0];
        hdvls_pkg::REG_ENH_ENABLE:      cfg_nxt.enh_enable      = pwdata[0];
        hdvls_pkg::REG_WRAPPER_TYPE:    cfg_nxt.wrapper_type    = pwdata[5:0];
        hdvls_pkg::REG_RPU_TYPE:        cfg_nxt.rpu_type        = pwdata[5:0];
        hdvls_pkg::REG_SHORT_CODE_MASK: cfg_nxt.short_code_mask = pwdata[63:0];
        hdvls_pkg::REG_WARN_THRESHOLD:  cfg_nxt.warn_threshold  = pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      hdvls_pkg::REG_BASE_ENABLE:     prdata = {63'd0, cfg_r.base_enable};
      hdvls_pkg::REG_ENH_ENABLE:      prdata = {63'd0, cfg_r.enh_enable};
      hdvls_pkg::REG_WRAPPER_TYPE:    prdata = {58'd0, cfg_r.wrapper_type};
      hdvls_pkg::REG_RPU_TYPE:        prdata = {58'd0, cfg_r.rpu_type};
      hdvls_pkg::REG_SHORT_CODE_MASK: prdata = cfg_r.short_code_mask;
      hdvls_pkg::REG_WARN_THRESHOLD:  prdata = {58'd0, cfg_r.warn_threshold};
      default:                        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_enable     <= hdvls_pkg::RST_BASE_ENABLE;
      cfg_r.enh_enable      <= hdvls_pkg::RST_ENH_ENABLE;
      cfg_r.wrapper_type    <= hdvls_pkg::RST_WRAPPER_TYPE;
      cfg_r.rpu_type        <= hdvls_pkg::RST_RPU_TYPE;
      cfg_r.short_code_mask <= hdvls_pkg::RST_SHORT_CODE_MASK;
      cfg_r.warn_threshold  <= hdvls_pkg::RST_WARN_THRESHOLD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/hdvls_front.sv]
// front end: start code scan, unit header parse, routing, run building
// depends on hdvls_pkg and the assertion macros header
`include "hevc_dolby_vision_layer_splitter_macros.svh"

module hdvls_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  hdvls_pkg::in_item_t  in_data,
  output logic                 in_stall,
  input  hdvls_pkg::cfg_t      cfg,
  input  logic                 q_full,
  output hdvls_pkg::push_t     push
);

  typedef enum logic [5:0] {
    PH_SEARCH = 6'b000001,
    PH_H0     = 6'b000010,
    PH_H1     = 6'b000100,
    PH_W0     = 6'b001000,
    PH_W1     = 6'b010000,
    PH_BODY   = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    ROUTE_NONE = 2'd0,
    ROUTE_BASE = 2'd1,
    ROUTE_ENH  = 2'd2
  } route_t;

  typedef struct packed {
    phase_t                        phase;
    logic [1:0]                    zero_run;
    logic [7:0]                    head0;
    route_t                        route;
    logic [hdvls_pkg::TYPE_W-1:0]  rpu_seen;
    logic                          wrapper_seen;
  } scan_t;

  typedef struct packed {
    scan_t                                 s;
    logic [hdvls_pkg::RUN_CNT_W-1:0]       cnt;
    logic [hdvls_pkg::MAX_RUN-1:0][7:0]    data;
    logic                                  first;
  } emit_t;

  // one unit byte taken through the header parser
  function automatic emit_t commit_f(input scan_t s, input logic [7:0] d,
                                     input hdvls_pkg::cfg_t c);
    emit_t                        e;
    logic [hdvls_pkg::TYPE_W-1:0] t;
    logic                         hdr;
    logic                         body;
    logic                         on;
    e     = '0;
    e.s   = s;
    t     = s.head0[6:1];
    hdr   = 1'b0;
    body  = 1'b0;
    unique case (s.phase)
      PH_H0: begin
        e.s.head0 = d;
        e.s.phase = PH_H1;
      end
      PH_H1: begin
        if (d == 8'h00) begin
          e.s.phase = PH_SEARCH;
          e.s.route = ROUTE_NONE;
        end else if (t == c.wrapper_type) begin
          e.s.wrapper_seen = 1'b1;
          e.s.route        = ROUTE_ENH;
          e.s.phase        = PH_W0;
        end else begin
          if (t == c.rpu_type) begin
            if (s.rpu_seen != hdvls_pkg::RPU_COUNT_MAX) begin
              e.s.rpu_seen = s.rpu_seen + 6'd1;
            end
            e.s.route = ROUTE_ENH;
          end else begin
            e.s.route = ROUTE_BASE;
          end
          hdr       = 1'b1;
          e.s.phase = PH_BODY;
        end
      end
      PH_W0: begin
        e.s.head0 = d;
        e.s.phase = PH_W1;
      end
      PH_W1: begin
        if (d == 8'h00) begin
          e.s.phase = PH_SEARCH;
          e.s.route = ROUTE_NONE;
        end else begin
          hdr       = 1'b1;
          e.s.phase = PH_BODY;
        end
      end
      PH_BODY: body = 1'b1;
      PH_SEARCH: ;
      default: ;
    endcase
    on = (e.s.route == ROUTE_BASE && c.base_enable) ||
         (e.s.route == ROUTE_ENH && c.enh_enable);
    if (on && hdr) begin
      e.first = 1'b1;
      if (c.short_code_mask[t]) begin
        e.cnt     = 3'd5;
        e.data[0] = hdvls_pkg::SYNC_BYTES[2];
        e.data[1] = hdvls_pkg::SYNC_BYTES[1];
        e.data[2] = hdvls_pkg::SYNC_BYTES[0];
        e.data[3] = s.head0;
        e.data[4] = d;
      end else begin
        e.cnt     = 3'd6;
        e.data[0] = hdvls_pkg::SYNC_BYTES[3];
        e.data[1] = hdvls_pkg::SYNC_BYTES[2];
        e.data[2] = hdvls_pkg::SYNC_BYTES[1];
        e.data[3] = hdvls_pkg::SYNC_BYTES[0];
        e.data[4] = s.head0;
        e.data[5] = d;
      end
    end else if (on && body) begin
      e.cnt     = 3'd1;
      e.data[0] = d;
    end
    return e;
  endfunction

  scan_t           scan_r, scan_nxt;
  logic            warned_r, warned_nxt;
  logic            pending_r, pending_nxt;
  scan_t           s1, sa, sb, sc;
  emit_t           em [3];
  logic [2:0]      gate;
  logic [1:0]      nz;
  logic            use_b;
  logic [7:0]      b;
  logic            last;
  logic            accept;
  logic            pend;
  logic [3:0]      base;
  logic [3:0]      slot;
  hdvls_pkg::run_t run;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign b        = in_data.in_byte;
  assign last     = in_data.packet_end;

  always_comb begin
    s1    = scan_r;
    nz    = 2'd0;
    use_b = 1'b0;
    if (scan_r.phase == PH_SEARCH) begin
      if (b == 8'h00) begin
        if (scan_r.zero_run != 2'd2) s1.zero_run = scan_r.zero_run + 2'd1;
      end else if (b == 8'h01 && scan_r.zero_run == 2'd2) begin
        s1.phase    = PH_H0;
        s1.route    = ROUTE_NONE;
        s1.zero_run = 2'd0;
      end else begin
        s1.zero_run = 2'd0;
      end
    end else if (b == 8'h00) begin
      if (scan_r.zero_run != 2'd2) begin
        s1.zero_run = scan_r.zero_run + 2'd1;
        if (last) nz = s1.zero_run;
      end else begin
        // third zero: held zeros were trailing
        s1.phase = PH_SEARCH;
        s1.route = ROUTE_NONE;
      end
    end else if (b == 8'h01 && scan_r.zero_run == 2'd2) begin
      s1.phase    = PH_H0;
      s1.route    = ROUTE_NONE;
      s1.zero_run = 2'd0;
    end else begin
      nz          = scan_r.zero_run;
      use_b       = 1'b1;
      s1.zero_run = 2'd0;
    end

    em[0] = commit_f(s1, 8'h00, cfg);
    sa    = (nz != 2'd0) ? em[0].s : s1;
    em[1] = commit_f(sa, 8'h00, cfg);
    sb    = (nz == 2'd2) ? em[1].s : sa;
    em[2] = commit_f(sb, b, cfg);
    sc    = use_b ? em[2].s : sb;
    gate  = {use_b, nz == 2'd2, nz != 2'd0};

    run  = '0;
    base = '0;
    slot = '0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < hdvls_pkg::MAX_RUN; j++) begin
        slot = base + 4'(j);
        if (gate[k] && 3'(j) < em[k].cnt && slot < 4'(hdvls_pkg::MAX_RUN)) begin
          run.data[slot[2:0]] = em[k].data[j];
          if (j == 0) run.first[slot[2:0]] = em[k].first;
        end
      end
      if (gate[k]) base = base + {1'b0, em[k].cnt};
    end
    run.cnt   = base[2:0];
    run.layer = (sc.route == ROUTE_ENH);

    scan_nxt   = sc;
    warned_nxt = warned_r;
    pend       = pending_r;
    if (last) begin
      scan_nxt.phase    = PH_SEARCH;
      scan_nxt.route    = ROUTE_NONE;
      scan_nxt.zero_run = 2'd0;
      if (!warned_r && !sc.wrapper_seen && sc.rpu_seen > cfg.warn_threshold) begin
        warned_nxt = 1'b1;
        pend       = 1'b1;
      end
    end
    run.warn    = pend;
    pending_nxt = pend && (run.cnt == '0);

    push.valid = accept && (run.cnt != '0);
    push.run   = run;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r.phase        <= PH_SEARCH;
      scan_r.zero_run     <= 2'd0;
      scan_r.head0        <= 8'h00;
      scan_r.route        <= ROUTE_NONE;
      scan_r.rpu_seen     <= '0;
      scan_r.wrapper_seen <= 1'b0;
      warned_r            <= 1'b0;
      pending_r           <= 1'b0;
    end else if (accept) begin
      scan_r    <= scan_nxt;
      warned_r  <= warned_nxt;
      pending_r <= pending_nxt;
    end
  end

  `HDVLS_ASSERT_SAME(a_run_fits, push.valid, push.run.cnt <= 3'(hdvls_pkg::MAX_RUN), "run too long")
  `HDVLS_ASSERT_NEXT(a_pending_needs_warned, pending_r, warned_r, "pending warning without warned")

endmodule

[rtl/hdvls_queue.sv]
// short queue of runs between the front end and the output serialiser
// depends on hdvls_pkg and the assertion macros header
`include "hevc_dolby_vision_layer_splitter_macros.svh"

module hdvls_queue #(
  parameter int DEPTH = hdvls_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hdvls_pkg::push_t  push,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output hdvls_pkg::run_t   head_run
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hdvls_pkg::run_t    mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_run   = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) count_nxt = count_r + CNT_W'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push.run;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `HDVLS_ASSERT_SAME(a_no_push_full, push.valid, !full, "push into full queue")
  `HDVLS_ASSERT_NEXT(a_push_holds, push.valid && !pop, count_r != '0, "pushed run lost")

endmodule

[rtl/hdvls_back.sv]
// back end: serialises queued runs into result items, one per cycle while out_stall is low
// depends on hdvls_pkg and the assertion macros header
`include "hevc_dolby_vision_layer_splitter_macros.svh"

module hdvls_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  hdvls_pkg::run_t      head_run,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hdvls_pkg::out_item_t out_data
);

  logic [hdvls_pkg::RUN_CNT_W-1:0] idx_r, idx_nxt;
  logic                            out_valid_r, out_valid_nxt;
  hdvls_pkg::out_item_t            out_data_r, out_data_nxt;
  logic                            adv;
  logic                            take;
  logic                            at_end;

  assign adv       = !out_valid_r || !out_stall;
  assign take      = adv && head_valid;
  assign at_end    = (idx_r == head_run.cnt - 3'd1);
  assign pop       = take && at_end;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (take) begin
      idx_nxt                        = at_end ? '0 : idx_r + 3'd1;
      out_valid_nxt                  = 1'b1;
      out_data_nxt.out_byte          = head_run.data[idx_r];
      out_data_nxt.out_layer         = head_run.layer;
      out_data_nxt.unit_first        = head_run.first[idx_r];
      out_data_nxt.run_last          = at_end;
      out_data_nxt.single_layer_warn = at_end && head_run.warn;
    end else if (adv) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `HDVLS_ASSERT_SAME(a_head_not_empty, head_valid, head_run.cnt != '0, "empty run queued")
  `HDVLS_ASSERT_SAME(a_warn_on_last, out_valid_r && out_data_r.single_layer_warn,
                     out_data_r.run_last, "warning off the last item of a run")

endmodule

[rtl/hevc_dolby_vision_layer_splitter.sv]
// an accepted byte's first result item is stored in the run queue, then registered out;
// throughput: one input byte per cycle while in_stall is low, one result item per cycle
// while out_stall is low, so a byte causing n results holds the output serialiser for n
// items; QUEUE_DEPTH run queue entries absorb start code bursts before in_stall rises
// reset: synchronous active-low rst_n clears scan state, counters, queue and output valid,
// configuration registers return to their reset values
module hevc_dolby_vision_layer_splitter #(
  parameter int QUEUE_DEPTH = hdvls_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  hdvls_pkg::in_item_t              in_data,
  output logic                             in_stall,
  output logic                             out_valid,
  input  logic                             out_stall,
  output hdvls_pkg::out_item_t             out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hdvls_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [hdvls_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [hdvls_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);

  hdvls_pkg::cfg_t  cfg;
  hdvls_pkg::push_t push;
  hdvls_pkg::run_t  head_run;
  logic             q_full;
  logic             head_valid;
  logic             pop;

  hdvls_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hdvls_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push)
  );

  hdvls_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_run   (head_run)
  );

  hdvls_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_run   (head_run),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for hevc_dolby_vision_layer_splitter
// drives byte packets and register writes, predicts every layer byte; needs hdvls_pkg
module tb;

  typedef enum logic [2:0] {
    SCAN_SEARCH, SCAN_HDR0, SCAN_HDR1, SCAN_WRAP0, SCAN_WRAP1, SCAN_BODY
  } scan_t;
  typedef enum logic [1:0] {ROUTE_NONE, ROUTE_BASE, ROUTE_ENH} route_t;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRINT_CAP = 20;

  // {packet_end, byte}
  localparam logic [8:0] DIRECTED_ITEMS [27] = '{
    9'h0FF, 9'h000, 9'h000, 9'h001, 9'h040, 9'h001, 9'h0FF, 9'h000, 9'h000,
    9'h000, 9'h001, 9'h07E, 9'h001, 9'h026, 9'h001, 9'h000, 9'h000, 9'h001,
    9'h07C, 9'h000, 9'h002, 9'h000, 9'h000, 9'h001, 9'h07C, 9'h001, 9'h100
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  hdvls_pkg::in_item_t in_data = '0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  hdvls_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [hdvls_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [hdvls_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [hdvls_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  hevc_dolby_vision_layer_splitter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  hdvls_pkg::cfg_t split_cfg;
  scan_t scan = SCAN_SEARCH;
  route_t route = ROUTE_NONE;
  int zero_run = 0;
  logic [7:0] hdr0 = '0;
  logic [7:0] hdr1 = '0;
  logic [5:0] rpu_count = '0;
  logic wrap_seen = 1'b0;
  logic warned = 1'b0;
  logic warn_pending = 1'b0;

  hdvls_pkg::out_item_t step_bytes [$];
  hdvls_pkg::out_item_t layer_bytes_due [$];
  hdvls_pkg::in_item_t stream_q [$];

  logic calm = 1'b0;
  int errors = 0;
  int bytes_in = 0;
  int bytes_queued = 0;
  int bytes_checked = 0;
  int packets = 0;
  int warn_hits = 0;
  int idle_cycles = 0;
  hdvls_pkg::out_item_t want;

  function automatic void emit_byte(logic [7:0] b, logic first);
    hdvls_pkg::out_item_t r;
    if (!((route == ROUTE_BASE && split_cfg.base_enable) ||
          (route == ROUTE_ENH && split_cfg.enh_enable)) ||
        step_bytes.size() >= hdvls_pkg::MAX_RUN)
      return;
    r = '0;
    r.out_byte = b;
    r.out_layer = (route == ROUTE_ENH);
    r.unit_first = first;
    step_bytes = {step_bytes, r};
  endfunction

  function automatic void emit_sync_prefix(logic [5:0] t);
    int n;
    n = split_cfg.short_code_mask[t] ? 3 : 4;
    for (int i = n - 1; i >= 0; i--)
      emit_byte((i == 0) ? 8'h01 : 8'h00, i == n - 1);
  endfunction

  function automatic void open_unit();
    scan = SCAN_HDR0;
    route = ROUTE_NONE;
    zero_run = 0;
  endfunction

  function automatic void take_unit_byte(logic [7:0] d);
    logic [5:0] t;
    case (scan)
      SCAN_HDR0: begin
        hdr0 = d;
        scan = SCAN_HDR1;
      end
      SCAN_HDR1: begin
        if (d == 8'h00) begin
          scan = SCAN_SEARCH;
          route = ROUTE_NONE;
        end else begin
          hdr1 = d;
          t = hdr0[6:1];
          if (t == split_cfg.wrapper_type) begin
            wrap_seen = 1'b1;
            route = ROUTE_ENH;
            scan = SCAN_WRAP0;
          end else begin
            if (t == split_cfg.rpu_type) begin
              if (rpu_count != hdvls_pkg::RPU_COUNT_MAX) rpu_count++;
              route = ROUTE_ENH;
            end else begin
              route = ROUTE_BASE;
            end
            emit_sync_prefix(t);
            emit_byte(hdr0, 1'b0);
            emit_byte(hdr1, 1'b0);
            scan = SCAN_BODY;
          end
        end
      end
      SCAN_WRAP0: begin
        hdr0 = d;
        scan = SCAN_WRAP1;
      end
      SCAN_WRAP1: begin
        if (d == 8'h00) begin
          scan = SCAN_SEARCH;
          route = ROUTE_NONE;
        end else begin
          emit_sync_prefix(hdr0[6:1]);
          emit_byte(hdr0, 1'b0);
          emit_byte(d, 1'b0);
          scan = SCAN_BODY;
        end
      end
      SCAN_BODY: emit_byte(d, 1'b0);
      default: ;
    endcase
  endfunction

  function automatic void split_byte(hdvls_pkg::in_item_t it);
    logic [7:0] b;
    hdvls_pkg::out_item_t r;
    int k;
    step_bytes.delete();
    b = it.in_byte;
    if (scan == SCAN_SEARCH) begin
      if (b == 8'h00) begin
        if (zero_run < 2) zero_run++;
      end else if (b == 8'h01 && zero_run == 2) begin
        open_unit();
      end else begin
        zero_run = 0;
      end
    end else if (b == 8'h00) begin
      if (zero_run < 2) begin
        zero_run++;
      end else begin
        scan = SCAN_SEARCH;
        route = ROUTE_NONE;
      end
    end else if (b == 8'h01 && zero_run == 2) begin
      open_unit();
    end else begin
      for (k = 0; k < zero_run && scan != SCAN_SEARCH; k++) take_unit_byte(8'h00);
      if (scan != SCAN_SEARCH) take_unit_byte(b);
      zero_run = 0;
    end
    if (it.packet_end) begin
      for (k = 0; k < zero_run && scan != SCAN_SEARCH; k++) take_unit_byte(8'h00);
      scan = SCAN_SEARCH;
      route = ROUTE_NONE;
      zero_run = 0;
      if (!warned && !wrap_seen && rpu_count > split_cfg.warn_threshold) begin
        warned = 1'b1;
        warn_pending = 1'b1;
      end
    end
    if (step_bytes.size() > 0) begin
      k = step_bytes.size() - 1;
      r = step_bytes[k];
      r.run_last = 1'b1;
      if (warn_pending) begin
        r.single_layer_warn = 1'b1;
        warn_pending = 1'b0;
      end
      step_bytes[k] = r;
    end
    layer_bytes_due = {layer_bytes_due, step_bytes};
  endfunction

  task automatic report_mismatch(input string what, input hdvls_pkg::out_item_t got,
                                 input hdvls_pkg::out_item_t exp_item);
    errors++;
    if (errors <= PRINT_CAP)
      $display("mismatch %s: got %h/%0d/%0d/%0d/%0d want %h/%0d/%0d/%0d/%0d", what,
               got.out_byte, got.out_layer, got.unit_first, got.run_last,
               got.single_layer_warn, exp_item.out_byte, exp_item.out_layer,
               exp_item.unit_first, exp_item.run_last, exp_item.single_layer_warn);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        split_byte(in_data);
        bytes_in++;
      end
      if (!in_valid || !in_stall) begin
        if (stream_q.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
          in_data <= stream_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 19);
      if (out_valid && !out_stall) begin
        if (out_data.single_layer_warn) warn_hits++;
        if (layer_bytes_due.size() == 0) begin
          report_mismatch("unexpected item", out_data, '0);
        end else begin
          want = layer_bytes_due.pop_front();
          bytes_checked++;
          if (out_data.out_byte !== want.out_byte || out_data.out_layer !== want.out_layer ||
              out_data.unit_first !== want.unit_first ||
              out_data.run_last !== want.run_last ||
              out_data.single_layer_warn !== want.single_layer_warn)
            report_mismatch("field", out_data, want);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      hdvls_pkg::REG_BASE_ENABLE:     split_cfg.base_enable = val[0];
      hdvls_pkg::REG_ENH_ENABLE:      split_cfg.enh_enable = val[0];
      hdvls_pkg::REG_WRAPPER_TYPE:    split_cfg.wrapper_type = val[5:0];
      hdvls_pkg::REG_RPU_TYPE:        split_cfg.rpu_type = val[5:0];
      hdvls_pkg::REG_SHORT_CODE_MASK: split_cfg.short_code_mask = val;
      hdvls_pkg::REG_WARN_THRESHOLD:  split_cfg.warn_threshold = val[5:0];
      default: ;
    endcase
  endtask

  task automatic set_layers(input logic base_en, input logic enh_en, input logic [5:0] wrap_t,
                            input logic [5:0] rpu_t, input logic [63:0] mask,
                            input logic [5:0] thresh);
    write_reg(hdvls_pkg::REG_BASE_ENABLE, {63'd0, base_en});
    write_reg(hdvls_pkg::REG_ENH_ENABLE, {63'd0, enh_en});
    write_reg(hdvls_pkg::REG_WRAPPER_TYPE, {58'd0, wrap_t});
    write_reg(hdvls_pkg::REG_RPU_TYPE, {58'd0, rpu_t});
    write_reg(hdvls_pkg::REG_SHORT_CODE_MASK, mask);
    write_reg(hdvls_pkg::REG_WARN_THRESHOLD, {58'd0, thresh});
  endtask

  task automatic queue_packet(input logic [7:0] pkt [$]);
    hdvls_pkg::in_item_t it;
    foreach (pkt[i]) begin
      it.in_byte = pkt[i];
      it.packet_end = (i == pkt.size() - 1);
      stream_q = {stream_q, it};
      bytes_queued++;
    end
    packets++;
  endtask

  // mostly well-formed units with random content, some noise and broken units
  task automatic gen_packet(input bit with_wrap);
    logic [7:0] pkt [$];
    logic [7:0] hb;
    logic [5:0] t;
    int roll;
    int nb;
    if (with_wrap && $urandom_range(9) == 0) begin
      nb = $urandom_range(1, 10);
      repeat (nb) begin
        roll = $urandom_range(3);
        hb = 8'($urandom_range(0, 255));
        pkt = {pkt, (roll == 0) ? 8'h00 : (roll == 1) ? 8'h01 : hb};
      end
    end else begin
      if ($urandom_range(6) == 0) pkt = {pkt, 8'($urandom_range(1, 255))};
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(3) == 0) pkt = {pkt, 8'h00};
        pkt = {pkt, 8'h00, 8'h00, 8'h01};
        roll = $urandom_range(99);
        if (with_wrap && roll < 30) begin
          t = split_cfg.wrapper_type;
        end else if (roll < 60) begin
          t = split_cfg.rpu_type;
        end else begin
          t = 6'($urandom_range(0, 63));
          if (!with_wrap && t == split_cfg.wrapper_type) t = split_cfg.rpu_type;
        end
        hb = 8'($urandom_range(0, 255));
        hb[6:1] = t;
        pkt = {pkt, hb};
        roll = $urandom_range(99);
        if (roll < 8) begin
          // one byte unit
        end else if (roll < 14) begin
          pkt = {pkt, 8'h00, 8'($urandom_range(2, 255))};
        end else begin
          pkt = {pkt, 8'($urandom_range(1, 255))};
          if (t == split_cfg.wrapper_type) begin
            pkt = {pkt, 8'($urandom_range(0, 255))};
            if (roll < 20) pkt = {pkt, 8'h00};
            pkt = {pkt, 8'($urandom_range(2, 255))};
          end
          nb = $urandom_range(0, 6);
          repeat (nb) begin
            roll = $urandom_range(9);
            if (roll < 2) begin
              repeat ($urandom_range(1, 3)) pkt = {pkt, 8'h00};
            end else if (roll == 2) begin
              pkt = {pkt, 8'h00, 8'h00, 8'h03};
            end else begin
              pkt = {pkt, 8'($urandom_range(0, 255))};
            end
          end
        end
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) pkt = {pkt, 8'h00};
      end
    end
    queue_packet(pkt);
  endtask

  task automatic fill_random(input int n, input bit with_wrap);
    int target;
    @(negedge clk);
    target = bytes_queued + n;
    while (bytes_queued < target) gen_packet(with_wrap);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (stream_q.size() != 0 || in_valid || layer_bytes_due.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  initial begin
    logic [7:0] dir_pkt [$];
    split_cfg.base_enable = hdvls_pkg::RST_BASE_ENABLE;
    split_cfg.enh_enable = hdvls_pkg::RST_ENH_ENABLE;
    split_cfg.wrapper_type = hdvls_pkg::RST_WRAPPER_TYPE;
    split_cfg.rpu_type = hdvls_pkg::RST_RPU_TYPE;
    split_cfg.short_code_mask = hdvls_pkg::RST_SHORT_CODE_MASK;
    split_cfg.warn_threshold = hdvls_pkg::RST_WARN_THRESHOLD;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // no wrapper yet, enhancement muted so the warning may wait for a base byte
    set_layers(1'b1, 1'b0, 6'd63, 6'd62, {$urandom, $urandom}, 6'($urandom_range(0, 1)));
    fill_random(15, 1'b0);
    wait_idle();

    set_layers(hdvls_pkg::RST_BASE_ENABLE, hdvls_pkg::RST_ENH_ENABLE,
               hdvls_pkg::RST_WRAPPER_TYPE, hdvls_pkg::RST_RPU_TYPE,
               hdvls_pkg::RST_SHORT_CODE_MASK, hdvls_pkg::RST_WARN_THRESHOLD);
    @(negedge clk);
    for (int i = 0; i < 27; i++) begin
      dir_pkt = {dir_pkt, DIRECTED_ITEMS[i][7:0]};
      if (DIRECTED_ITEMS[i][8]) begin
        queue_packet(dir_pkt);
        dir_pkt.delete();
      end
    end
    wait_idle();

    calm = 1'b1;
    set_layers(1'b1, 1'b1, 6'd63, 6'd62, 64'd0, 6'd0);
    fill_random(35, 1'b1);
    wait_idle();
    calm = 1'b0;

    set_layers(1'b0, 1'b1, 6'd0, 6'd1, {64{1'b1}}, 6'd63);
    fill_random(30, 1'b1);
    wait_idle();

    set_layers(1'b1, 1'b0, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
               {$urandom, $urandom}, 6'($urandom_range(0, 63)));
    fill_random(30, 1'b1);
    wait_idle();

    set_layers(1'b0, 1'b0, 6'd63, 6'd62, {$urandom, $urandom}, 6'd63);
    fill_random(15, 1'b1);
    wait_idle();

    set_layers(1'b1, 1'b1, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
               {$urandom, $urandom}, 6'd0);
    fill_random(35, 1'b1);
    wait_idle();

    $display("summary: %0d bytes in %0d packets over seven register settings", bytes_in,
             packets);
    $display("summary: %0d layer bytes checked, %0d warning flags, %0d mismatches",
             bytes_checked, warn_hits, errors);
    if (errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
